[src/tgr_pkg.sv]
// Shared types, constants and palette functions for the text glyph renderer.
`default_nettype none

package tgr_pkg;

  // Fixed field widths of the item and result beats.
  localparam int unsigned FONT_AW    = 12;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned COLS_W     = 8;
  localparam int unsigned FW_W       = 12;
  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned QUAD_W     = 64;
  localparam int unsigned PIX_W      = 16;

  // Divider runs one quotient bit per cycle.
  localparam int unsigned DIV_STEPS  = POS_W;
  localparam int unsigned DIV_CNT_W  = 4;

  // Register reset values and the character drawn in place of NUL.
  localparam logic [COLS_W-1:0] COLS_RESET  = 8'd80;
  localparam logic [FW_W-1:0]   FW_RESET    = 12'd640;
  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'd32;

  // Configuration register indexes.
  typedef enum logic {
    REG_TEXT_COLUMNS = 1'b0,
    REG_FRAME_WIDTH  = 1'b1
  } reg_index_t;

  // Input item modes.
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_DRAW = 1'b1
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_MULT,
    ST_PRIME,
    ST_RUN
  } state_t;

  // Control decoded combinationally from the state and the output handshake.
  typedef struct packed {
    logic in_busy;
    logic out_load;
  } ctrl_t;

  // Fixed 16-entry ANSI palette in BGR565.
  function automatic logic [PIX_W-1:0] palette(input logic [COLOR_W-1:0] idx);
    logic [PIX_W-1:0] rgb;
    unique case (idx)
      4'd0:    rgb = 16'h0000;
      4'd1:    rgb = 16'h29DB;
      4'd2:    rgb = 16'h05C0;
      4'd3:    rgb = 16'h063F;
      4'd4:    rgb = 16'hBB60;
      4'd5:    rgb = 16'h712E;
      4'd6:    rgb = 16'hEDA5;
      4'd7:    rgb = 16'hBDD7;
      4'd8:    rgb = 16'h52AA;
      4'd9:    rgb = 16'h001F;
      4'd10:   rgb = 16'h57EA;
      4'd11:   rgb = 16'h57FF;
      4'd12:   rgb = 16'hF800;
      4'd13:   rgb = 16'hF81F;
      4'd14:   rgb = 16'hFFE0;
      default: rgb = 16'hFFFF;
    endcase
    return rgb;
  endfunction

  // Four pixels from a nibble of glyph bits; the top bit is the leftmost pixel.
  function automatic logic [QUAD_W-1:0] make_quad(input logic [3:0] bits,
                                                  input logic [PIX_W-1:0] fg,
                                                  input logic [PIX_W-1:0] bg);
    logic [QUAD_W-1:0] quad;
    quad = '0;
    for (int k = 0; k < 4; k++) begin
      quad[k*PIX_W +: PIX_W] = bits[3-k] ? fg : bg;
    end
    return quad;
  endfunction

endpackage

`default_nettype wire

[src/text_glyph_renderer_top.sv]
// Top level of the text glyph renderer: glyph store, divider and row sequencer.
//
// Load items each write one byte of the glyph store and are taken while the
// sequencer is idle. A draw item runs the bit-serial divider that splits the
// cell position into row and column, then the row and frame-width scaling
// steps, then a prime state that starts the glyph store read, and then one
// result beat leaves per cycle while the output is not stalled, two per glyph
// row, with the next row read from the store ahead of it. The output
// register holds the final beat of a cell while the next item is taken. There
// is no clearing pass: glyph entries must be loaded before they are drawn.
`default_nettype none

module text_glyph_renderer_top #(
  parameter int unsigned CELL_ROWS    = 16,
  parameter int unsigned GLYPH_COUNT  = 256
) (
  input  wire                          clk,
  input  wire                          rst,
  // Configuration write port.
  input  wire                          cfg_write,
  input  wire                          cfg_index,
  input  wire  [tgr_pkg::FW_W-1:0]     cfg_data,
  // Input item channel.
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          mode,
  input  wire  [tgr_pkg::FONT_AW-1:0]  font_address,
  input  wire  [7:0]                   font_byte,
  input  wire  [tgr_pkg::POS_W-1:0]    cell_position,
  input  wire  [tgr_pkg::CHAR_W-1:0]   char_code,
  input  wire  [tgr_pkg::COLOR_W-1:0]  fore_color,
  input  wire  [tgr_pkg::COLOR_W-1:0]  back_color,
  // Result channel.
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [tgr_pkg::ADDR_W-1:0]   pixel_address,
  output logic [tgr_pkg::QUAD_W-1:0]   pixel_quad,
  output logic                         last
);

  localparam int unsigned Y_W    = $clog2(CELL_ROWS);
  localparam int unsigned LINE_W = tgr_pkg::POS_W + $clog2(CELL_ROWS + 1);
  localparam logic [Y_W-1:0] Y_LAST = Y_W'(CELL_ROWS - 1);

  // Configuration registers.
  logic [tgr_pkg::COLS_W-1:0] text_columns;
  logic [tgr_pkg::FW_W-1:0]   frame_width;

  // Sequencer and datapath registers.
  tgr_pkg::state_t              state, state_next;
  tgr_pkg::ctrl_t               ctrl;
  logic [tgr_pkg::POS_W-1:0]    quot;
  logic [tgr_pkg::COLS_W-1:0]   rem;
  logic [tgr_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [LINE_W-1:0]            line;
  logic [tgr_pkg::ADDR_W-1:0]   line_addr;
  logic [tgr_pkg::FONT_AW-1:0]  glyph_base;
  logic [tgr_pkg::COLOR_W-1:0]  fg_idx, bg_idx;
  logic [Y_W-1:0]               y;
  logic                         half;
  logic [3:0]                   row_lo;

  // Glyph store.
  logic [7:0]                   glyph_mem [tgr_pkg::STORE_DEPTH];
  logic [7:0]                   rd_data;
  logic [tgr_pkg::FONT_AW-1:0]  rd_addr;

  // Combinational helpers.
  logic                         in_accept, out_accept;
  logic [tgr_pkg::COLS_W-1:0]   cols;
  logic [tgr_pkg::COLS_W:0]     rem_shift;
  logic                         div_bit;
  logic [tgr_pkg::CHAR_W-1:0]   ch, ch_mod;
  logic                         row_end;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign cols       = (text_columns == '0) ? tgr_pkg::COLS_W'(1) : text_columns;
  assign row_end    = half && (y == Y_LAST);

  // One restoring divide step.
  assign rem_shift = {rem, quot[tgr_pkg::POS_W-1]};
  assign div_bit   = rem_shift >= {1'b0, cols};

  // Glyph index: NUL draws as space, then wrap into the glyph count.
  assign ch     = (char_code == '0) ? tgr_pkg::SPACE_CHAR : char_code;
  assign ch_mod = ({1'b0, ch} >= (tgr_pkg::CHAR_W + 1)'(GLYPH_COUNT))
                  ? ch - tgr_pkg::CHAR_W'(GLYPH_COUNT) : ch;

  // The right half addresses the next row, so it is in the read register in time.
  assign rd_addr = glyph_base + tgr_pkg::FONT_AW'(y) + tgr_pkg::FONT_AW'(half);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= tgr_pkg::COLS_RESET;
      frame_width  <= tgr_pkg::FW_RESET;
    end else if (cfg_write) begin
      unique case (tgr_pkg::reg_index_t'(cfg_index))
        tgr_pkg::REG_TEXT_COLUMNS: text_columns <= cfg_data[tgr_pkg::COLS_W-1:0];
        tgr_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Glyph store: loads write, the sequencer reads every cycle.
  always_ff @(posedge clk) begin
    if (in_accept && (tgr_pkg::mode_t'(mode) == tgr_pkg::MODE_LOAD)) begin
      glyph_mem[font_address] <= font_byte;
    end
    rd_data <= glyph_mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tgr_pkg::ST_IDLE: begin
        if (in_accept && (tgr_pkg::mode_t'(mode) == tgr_pkg::MODE_DRAW)) begin
          state_next = tgr_pkg::ST_DIVIDE;
        end
      end
      tgr_pkg::ST_DIVIDE: begin
        if (div_cnt == tgr_pkg::DIV_CNT_W'(tgr_pkg::DIV_STEPS - 1)) begin
          state_next = tgr_pkg::ST_SCALE;
        end
      end
      tgr_pkg::ST_SCALE: state_next = tgr_pkg::ST_MULT;
      tgr_pkg::ST_MULT:  state_next = tgr_pkg::ST_PRIME;
      tgr_pkg::ST_PRIME: state_next = tgr_pkg::ST_RUN;
      tgr_pkg::ST_RUN: begin
        if (ctrl.out_load && row_end) begin
          state_next = tgr_pkg::ST_IDLE;
        end
      end
      default: state_next = tgr_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    ctrl.in_busy  = (state != tgr_pkg::ST_IDLE);
    ctrl.out_load = (state == tgr_pkg::ST_RUN) && (!out_valid || !out_stall);
  end

  assign in_stall = ctrl.in_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item capture, division, address scaling and row stepping.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
      y       <= '0;
      half    <= 1'b0;
    end else begin
      unique case (state)
        tgr_pkg::ST_IDLE: begin
          if (in_accept) begin
            quot       <= cell_position;
            rem        <= '0;
            div_cnt    <= '0;
            glyph_base <= tgr_pkg::FONT_AW'(ch_mod) * tgr_pkg::FONT_AW'(CELL_ROWS);
            fg_idx     <= fore_color;
            bg_idx     <= back_color;
            y          <= '0;
            half       <= 1'b0;
          end
        end
        tgr_pkg::ST_DIVIDE: begin
          quot    <= {quot[tgr_pkg::POS_W-2:0], div_bit};
          rem     <= div_bit ? tgr_pkg::COLS_W'(rem_shift - {1'b0, cols})
                             : rem_shift[tgr_pkg::COLS_W-1:0];
          div_cnt <= div_cnt + 1'b1;
        end
        tgr_pkg::ST_SCALE: begin
          line <= LINE_W'(quot) * LINE_W'(CELL_ROWS);
        end
        tgr_pkg::ST_MULT: begin
          line_addr <= tgr_pkg::ADDR_W'(frame_width) * tgr_pkg::ADDR_W'(line);
        end
        tgr_pkg::ST_PRIME: begin
          line_addr <= line_addr + tgr_pkg::ADDR_W'({rem, 3'b000});
        end
        tgr_pkg::ST_RUN: begin
          if (ctrl.out_load) begin
            if (half) begin
              line_addr <= line_addr + tgr_pkg::ADDR_W'(frame_width);
              y         <= y + 1'b1;
              half      <= 1'b0;
            end else begin
              row_lo <= rd_data[3:0];
              half   <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      pixel_address <= line_addr + tgr_pkg::ADDR_W'({half, 2'b00});
      pixel_quad    <= tgr_pkg::make_quad(half ? row_lo : rd_data[7:4],
                                          tgr_pkg::palette(fg_idx),
                                          tgr_pkg::palette(bg_idx));
      last          <= row_end;
    end
  end

  // The divider remainder always stays below the column count.
  assert property (@(posedge clk) disable iff (rst)
    (state == tgr_pkg::ST_DIVIDE) |-> ({1'b0, rem} < {1'b0, cols}))
    else $error("divider remainder out of range");

  // A draw item starts the divider in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (tgr_pkg::mode_t'(mode) == tgr_pkg::MODE_DRAW))
      |=> (state == tgr_pkg::ST_DIVIDE))
    else $error("draw item did not start the divider");

  // Loading the final beat of a cell returns to idle with last set.
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.out_load && row_end) |=> ((state == tgr_pkg::ST_IDLE) && out_valid && last))
    else $error("final beat of a cell mishandled");

  // Only the final beat of a cell carries last.
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.out_load && !row_end) |=> !last)
    else $error("last raised before the end of a cell");

endmodule

`default_nettype wire
